// ===== sv/psft_pkg.sv =====
// Package for the packet steering block: category and register codes, header and
// decision records, and protocol constants. Used by every module of the block.
`default_nettype none

package psft_pkg;

   localparam int COUNT_W = 64;

   typedef enum logic [2:0] {
      CAT_SHORT      = 3'd0,
      CAT_ARP        = 3'd1,
      CAT_LATER_FRAG = 3'd2,
      CAT_ICMP       = 3'd3,
      CAT_HANDSHAKE  = 3'd4,
      CAT_REDIRECT   = 3'd5,
      CAT_NO_SOCKET  = 3'd6,
      CAT_OTHER      = 3'd7
   } category_type;

   typedef enum logic [1:0] {
      CSR_EXTRA_TYPE_A   = 2'd0,
      CSR_EXTRA_TYPE_B   = 2'd1,
      CSR_HANDSHAKE_PORT = 2'd2,
      CSR_SOCKET_BOUND   = 2'd3
   } csr_index_type;

   localparam logic [15:0] ETHERTYPE_ARP   = 16'h0806;
   localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
   localparam logic [15:0] ETHERTYPE_IPV6  = 16'h86DD;
   localparam logic [13:0] ETH_LEN         = 14'd14;
   localparam logic [13:0] IPV4_MIN_LEN    = 14'd34;
   localparam logic [14:0] UDP_HDR_EXTRA   = 15'd22;
   localparam logic [15:0] OFFSET_MASK     = 16'h1FFF;
   localparam logic [15:0] MORE_FRAGS      = 16'h2000;
   localparam logic [15:0] HIGH_BYTE       = 16'hFF00;
   localparam logic [7:0]  PROTO_ICMP      = 8'd1;
   localparam logic [7:0]  PROTO_UDP       = 8'd17;
   localparam logic [15:0] HANDSHAKE_RESET = 16'd7090;

   typedef struct packed {
      logic [13:0] frame_length;
      logic [15:0] ether_type;
      logic [3:0]  header_words;
      logic [7:0]  ip_protocol;
      logic [15:0] fragment_field;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] datagram_id;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } header_type;

   typedef struct packed {
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] datagram_id;
   } flow_key_type;

   typedef struct packed {
      logic [15:0] extra_type_a;
      logic [15:0] extra_type_b;
      logic [15:0] handshake_port;
      logic        socket_bound;
   } csr_type;

   typedef struct packed {
      logic refresh;
      logic insert;
   } table_cmd_type;

   typedef struct packed {
      category_type  category;
      logic          redirect;
      table_cmd_type cmd;
   } decision_type;

endpackage

`default_nettype wire

// ===== sv/psft_classify.sv =====
// Steering decision for one header: category, verdict and fragment table command.
// Depends on psft_pkg; takes the table hit from psft_frag_table.
`default_nettype none

module psft_classify import psft_pkg::*; (
   input  header_type   hdr,
   input  csr_type      csr,
   input  logic         hit,
   output decision_type dec
);

   logic        offset_nonzero;
   logic        more_frags;
   logic        udp_fits;
   logic        port_match;
   logic        extra_a;
   logic        extra_b;
   logic [14:0] udp_end;
   logic        redirect;

   assign offset_nonzero = (hdr.fragment_field & OFFSET_MASK) != 16'd0;
   assign more_frags     = (hdr.fragment_field & MORE_FRAGS) != 16'd0;
   assign udp_end        = UDP_HDR_EXTRA + {9'd0, hdr.header_words, 2'b00};
   assign udp_fits       = udp_end <= {1'b0, hdr.frame_length};
   assign port_match     = (hdr.dst_port == csr.handshake_port) ||
                           (hdr.src_port == csr.handshake_port);
   assign extra_a        = (csr.extra_type_a != 16'd0) &&
                           ((hdr.ether_type & HIGH_BYTE) == (csr.extra_type_a & HIGH_BYTE));
   assign extra_b        = (csr.extra_type_b != 16'd0) &&
                           ((hdr.ether_type & HIGH_BYTE) == (csr.extra_type_b & HIGH_BYTE));

   always_comb begin
      dec          = '0;
      dec.category = CAT_OTHER;
      redirect     = 1'b0;
      if (hdr.frame_length < ETH_LEN) begin
         dec.category = CAT_SHORT;
      end else if (hdr.ether_type == ETHERTYPE_ARP) begin
         dec.category = CAT_ARP;
      end else if (hdr.ether_type == ETHERTYPE_IPV4) begin
         if (hdr.frame_length < IPV4_MIN_LEN) begin
            dec.category = CAT_SHORT;
         end else if (offset_nonzero && hit) begin
            dec.category    = CAT_LATER_FRAG;
            dec.cmd.refresh = 1'b1;
         end else if (hdr.ip_protocol == PROTO_ICMP) begin
            dec.category = CAT_ICMP;
         end else if (hdr.ip_protocol == PROTO_UDP && udp_fits && port_match) begin
            dec.category   = CAT_HANDSHAKE;
            dec.cmd.insert = more_frags;
         end else begin
            redirect = 1'b1;
         end
      end else if (hdr.ether_type == ETHERTYPE_IPV6 || extra_a || extra_b) begin
         redirect = 1'b1;
      end
      if (redirect) begin
         dec.category = csr.socket_bound ? CAT_REDIRECT : CAT_NO_SOCKET;
         dec.redirect = csr.socket_bound;
      end
   end

endmodule

`default_nettype wire

// ===== sv/psft_frag_table.sv =====
// Fully associative fragment table with per-entry rank LRU and a parallel key compare.
// Depends on psft_pkg; driven by the decision from psft_classify.
`default_nettype none

module psft_frag_table import psft_pkg::*; #(
   parameter int TRACK_ENTRIES = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  flow_key_type  key,
   input  logic          advance,
   input  table_cmd_type cmd,
   output logic          hit
);

   localparam int RANK_W = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
   localparam logic [RANK_W-1:0] OLDEST = RANK_W'(TRACK_ENTRIES - 1);

   flow_key_type            key_ff   [TRACK_ENTRIES];
   logic                    valid_ff [TRACK_ENTRIES];
   logic [RANK_W-1:0]       rank_ff  [TRACK_ENTRIES];
   logic [TRACK_ENTRIES-1:0] match_vec;
   logic [TRACK_ENTRIES-1:0] victim_vec;
   logic [TRACK_ENTRIES-1:0] sel_vec;
   logic [RANK_W-1:0]       hit_rank;
   logic [RANK_W-1:0]       sel_rank;
   logic                    update;
   logic                    write_key;

   always_comb begin
      for (int i = 0; i < TRACK_ENTRIES; i++) begin
         match_vec[i]  = valid_ff[i] && (key_ff[i] == key);
         victim_vec[i] = rank_ff[i] == OLDEST;
      end
   end

   always_comb begin
      hit_rank = '0;
      for (int i = 0; i < TRACK_ENTRIES; i++) begin
         hit_rank = hit_rank | (match_vec[i] ? rank_ff[i] : '0);
      end
   end

   assign hit       = |match_vec;
   assign update    = advance && (cmd.refresh || cmd.insert);
   assign write_key = advance && cmd.insert && !hit;
   assign sel_vec   = hit ? match_vec : victim_vec;
   assign sel_rank  = hit ? hit_rank : OLDEST;

   for (genvar g = 0; g < TRACK_ENTRIES; g++) begin : g_entry
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
            rank_ff[g]  <= RANK_W'(g);
         end else if (update) begin
            if (sel_vec[g]) begin
               rank_ff[g] <= '0;
            end else if (rank_ff[g] < sel_rank) begin
               rank_ff[g] <= rank_ff[g] + 1'b1;
            end
            if (write_key && sel_vec[g]) begin
               valid_ff[g] <= 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (write_key && sel_vec[g]) begin
            key_ff[g] <= key;
         end
      end
   end

   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("fragment table holds a key twice");

   a_one_oldest: assert property (@(posedge clock) disable iff (reset)
      $onehot(victim_vec))
      else $error("fragment table ranks are not a permutation");

endmodule

`default_nettype wire

// ===== sv/psft_counters.sv =====
// Wrapping 64-bit total and per-category frame counters.
// Depends on psft_pkg for the category codes.
`default_nettype none

module psft_counters import psft_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  category_type       category,
   output logic [COUNT_W-1:0] total_next,
   output logic [COUNT_W-1:0] category_next
);

   logic [COUNT_W-1:0] count_ff [8];
   logic [COUNT_W-1:0] total_ff;
   logic [COUNT_W-1:0] unused_ff;
   logic [COUNT_W-1:0] sel_next;
   logic               counted;

   assign total_ff      = count_ff[CAT_SHORT];
   assign unused_ff     = count_ff[CAT_LATER_FRAG];
   assign counted       = (category != CAT_SHORT) && (category != CAT_LATER_FRAG);
   assign total_next    = total_ff + 1'b1;
   assign sel_next      = count_ff[category] + 1'b1;
   assign category_next = counted ? sel_next : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            count_ff[i] <= '0;
         end
      end else if (advance) begin
         count_ff[CAT_SHORT] <= total_next;
         if (counted) begin
            count_ff[category] <= sel_next;
         end
      end
   end

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> total_ff == $past(total_ff) + 1'b1)
      else $error("total counter did not advance by one");

   a_total_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(total_ff))
      else $error("total counter moved without an item");

   a_unused_slot: assert property (@(posedge clock) disable iff (reset)
      unused_ff == '0)
      else $error("later fragment slot was counted");

endmodule

`default_nettype wire

// ===== sv/packet_steering_with_fragment_table.sv =====
// Packet steering top level: configuration registers, input and result registers.
// Depends on psft_pkg, psft_classify, psft_frag_table and psft_counters.
//
// One item is taken per clock cycle at full rate. Each item is loaded into the input register
// when it is taken; its result is loaded into the result register and offered once it advances.
// A result that waits on rsp_ready holds the input register, and the input stalls only once both
// registers are full. The rate is set by the decision path between the two registers, whose
// widest part is the parallel key compare across all TRACK_ENTRIES fragment table entries;
// table ranks and counters update in the same cycle that the result is registered, so
// back-to-back items see each other's effects. No clearing pass is needed after reset.
`default_nettype none

module packet_steering_with_fragment_table import psft_pkg::*; #(
   parameter int TRACK_ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [13:0]        req_frame_length,
   input  logic [15:0]        req_ether_type,
   input  logic [3:0]         req_header_words,
   input  logic [7:0]         req_ip_protocol,
   input  logic [15:0]        req_fragment_field,
   input  logic [31:0]        req_source_address,
   input  logic [31:0]        req_dest_address,
   input  logic [15:0]        req_datagram_id,
   input  logic [15:0]        req_src_port,
   input  logic [15:0]        req_dst_port,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_verdict,
   output logic [2:0]         rsp_category,
   output logic [COUNT_W-1:0] rsp_total_count,
   output logic [COUNT_W-1:0] rsp_category_count
);

   csr_type            csr_ff;
   header_type         hdr_ff;
   header_type         hdr_in;
   logic               hdr_valid_ff;
   logic               rsp_valid_ff;
   logic               advance;
   logic               hit;
   decision_type       dec;
   flow_key_type       key;
   logic [COUNT_W-1:0] total_next;
   logic [COUNT_W-1:0] category_next;
   logic               verdict_ff;
   category_type       category_ff;
   logic [COUNT_W-1:0] total_ff;
   logic [COUNT_W-1:0] cat_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.extra_type_a   <= '0;
         csr_ff.extra_type_b   <= '0;
         csr_ff.handshake_port <= HANDSHAKE_RESET;
         csr_ff.socket_bound   <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_EXTRA_TYPE_A:   csr_ff.extra_type_a   <= csr_write_data;
            CSR_EXTRA_TYPE_B:   csr_ff.extra_type_b   <= csr_write_data;
            CSR_HANDSHAKE_PORT: csr_ff.handshake_port <= csr_write_data;
            CSR_SOCKET_BOUND:   csr_ff.socket_bound   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign advance   = hdr_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !hdr_valid_ff || advance;

   assign hdr_in = '{
      frame_length:   req_frame_length,
      ether_type:     req_ether_type,
      header_words:   req_header_words,
      ip_protocol:    req_ip_protocol,
      fragment_field: req_fragment_field,
      source_address: req_source_address,
      dest_address:   req_dest_address,
      datagram_id:    req_datagram_id,
      src_port:       req_src_port,
      dst_port:       req_dst_port
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_valid_ff <= 1'b0;
      end else if (req_ready) begin
         hdr_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         hdr_ff <= hdr_in;
      end
   end

   assign key = '{
      source_address: hdr_ff.source_address,
      dest_address:   hdr_ff.dest_address,
      datagram_id:    hdr_ff.datagram_id
   };

   psft_frag_table #(
      .TRACK_ENTRIES (TRACK_ENTRIES)
   ) u_frag_table (
      .clock   (clock),
      .reset   (reset),
      .key     (key),
      .advance (advance),
      .cmd     (dec.cmd),
      .hit     (hit)
   );

   psft_classify u_classify (
      .hdr (hdr_ff),
      .csr (csr_ff),
      .hit (hit),
      .dec (dec)
   );

   psft_counters u_counters (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .category      (dec.category),
      .total_next    (total_next),
      .category_next (category_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         verdict_ff   <= dec.redirect;
         category_ff  <= dec.category;
         total_ff     <= total_next;
         cat_count_ff <= category_next;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_category       = category_ff;
   assign rsp_total_count    = total_ff;
   assign rsp_category_count = cat_count_ff;

endmodule

`default_nettype wire
